// File: sv/sae_pkg.sv
// Shared types, codes and constants for the scalar autograd engine.
// No dependencies.
`default_nettype none
package sae_pkg;
    localparam int NodeCapacity = 256;
    localparam int FractionBits = 16;
    localparam int IdxW = 8;

    localparam logic [2:0] OP_CLEAR = 3'd0;
    localparam logic [2:0] OP_LEAF  = 3'd1;
    localparam logic [2:0] OP_ADD   = 3'd2;
    localparam logic [2:0] OP_MUL   = 3'd3;
    localparam logic [2:0] OP_EXP   = 3'd4;
    localparam logic [2:0] OP_BWD   = 3'd5;
    localparam logic [2:0] OP_READ  = 3'd6;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_BAD  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam logic [1:0] K_LEAF = 2'd0;
    localparam logic [1:0] K_ADD  = 2'd1;
    localparam logic [1:0] K_MUL  = 2'd2;
    localparam logic [1:0] K_EXP  = 2'd3;

    localparam logic [31:0] Log2eQ30 = 32'd1549082005;
    localparam logic [31:0] Ln2Q30   = 32'd744261118;

    // datapath commands
    localparam logic [3:0] C_NONE   = 4'd0;
    localparam logic [3:0] C_RDAB   = 4'd1;  // read value a,b
    localparam logic [3:0] C_ALU    = 4'd2;  // start add/mul/exp
    localparam logic [3:0] C_WNODE  = 4'd3;  // write new node
    localparam logic [3:0] C_GZERO  = 4'd4;  // zero gradient at counter
    localparam logic [3:0] C_GROOT  = 4'd5;  // set root gradient
    localparam logic [3:0] C_RDV    = 4'd6;  // read node v meta/grad/value
    localparam logic [3:0] C_RDC    = 4'd7;  // read child values/grads
    localparam logic [3:0] C_PROD   = 4'd8;  // start gradient products
    localparam logic [3:0] C_WGA    = 4'd9;  // write grad a
    localparam logic [3:0] C_WGB    = 4'd10; // write grad b
    localparam logic [3:0] C_RDRES  = 4'd11; // round the mul product into the result
    localparam logic [3:0] C_RDGB   = 4'd12; // reread grad b

    typedef struct packed {
        logic [3:0]      cmd;
        logic [2:0]      op;
        logic [IdxW-1:0] addr;
    } t_cmd;

    typedef struct packed {
        logic       busy;
        logic [1:0] kind;
    } t_stat;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [31:0] leaf_value;
        logic [7:0]  operand_a;
        logic [7:0]  operand_b;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  node_index;
        logic [31:0] node_value;
        logic [31:0] node_gradient;
    } t_rsp;

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {a[31], a} + {b[31], b};
        if (s[32] != s[31]) return s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        return s[31:0];
    endfunction

    // rounded Q product from a registered 64-bit product
    function automatic logic [31:0] sat_round(input logic [63:0] p);
        logic [63:0] r;
        logic [63:0] q;
        r = p + (64'd1 << (FractionBits - 1));
        q = 64'($signed(r) >>> FractionBits);
        if ($signed(q) > $signed(64'h7FFF_FFFF)) return 32'h7FFF_FFFF;
        if ($signed(q) < $signed(64'hFFFF_FFFF_8000_0000)) return 32'h8000_0000;
        return q[31:0];
    endfunction
endpackage
`default_nettype wire

// File: sv/sae_if.sv
// Valid/ready channel interfaces for request and response.
// Depends on sae_pkg.
`default_nettype none
interface sae_req_if;
    logic          valid;
    logic          ready;
    sae_pkg::t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface sae_rsp_if;
    logic          valid;
    logic          ready;
    sae_pkg::t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: sv/sae_ram.sv
// Generic single-write, dual-read RAM with registered read data.
// No dependencies.
`default_nettype none
module sae_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire [$clog2(DEPTH)-1:0] i_raddr0,
    input  wire [$clog2(DEPTH)-1:0] i_raddr1,
    output logic [WIDTH-1:0]        o_rdata0,
    output logic [WIDTH-1:0]        o_rdata1
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata0 <= r_mem[i_raddr0];
        o_rdata1 <= r_mem[i_raddr1];
    end
endmodule
`default_nettype wire

// File: sv/sae_exp.sv
// Iterative fixed-point exp unit; a new start is taken only while idle.
// Depends on sae_pkg.
`default_nettype none
module sae_exp (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_start,
    input  wire  [31:0] i_x,
    output logic        o_done,
    output logic [31:0] o_y
);
    localparam int S = sae_pkg::FractionBits + 30;

    localparam logic [2:0] E_IDLE = 3'd0;
    localparam logic [2:0] E_K    = 3'd1;
    localparam logic [2:0] E_Z    = 3'd2;
    localparam logic [2:0] E_ZR   = 3'd3;
    localparam logic [2:0] E_T    = 3'd4;
    localparam logic [2:0] E_DIV  = 3'd5;
    localparam logic [2:0] E_FIN  = 3'd6;

    logic [2:0]  r_st;
    logic [63:0] r_y;
    logic [63:0] r_k;
    logic [63:0] r_p;
    logic [31:0] r_z;
    logic [63:0] r_term;
    logic [63:0] r_sum;
    logic [2:0]  r_n;
    logic [63:0] r_quo;
    logic [31:0] r_res;
    logic        r_done;

    logic [63:0] w_frac;
    logic signed [63:0] w_sh;
    logic [63:0] w_v;
    logic [63:0] w_rs;
    logic [31:0] w_out;
    logic [31:0] w_recip;
    logic [5:0]  w_rsh;

    always_comb begin
        w_frac = (r_y - (r_k << S)) >> sae_pkg::FractionBits;
        w_sh = $signed(r_k) + 64'(sae_pkg::FractionBits) - 64'd30;
        w_v = r_sum << w_sh[5:0];
        w_rs = 64'd0 - w_sh;
        if (!w_sh[63]) begin
            if (w_sh > 64'sd32 || w_v > 64'h7FFF_FFFF) w_out = 32'h7FFF_FFFF;
            else w_out = w_v[31:0];
        end else if (w_rs >= 64'd63) begin
            w_out = 32'd0;
        end else begin
            w_out = 32'((r_sum + (64'd1 << (w_rs[5:0] - 6'd1))) >> w_rs[5:0]);
        end
    end

    // reciprocal and shift for an exact floor divide by n (term below 2^31)
    always_comb begin
        unique case (r_n)
            3'd2:    begin w_recip = 32'h8000_0000;  w_rsh = 6'd32; end
            3'd3:    begin w_recip = 32'd2863311531; w_rsh = 6'd33; end
            3'd4:    begin w_recip = 32'h8000_0000;  w_rsh = 6'd33; end
            3'd5:    begin w_recip = 32'd3435973837; w_rsh = 6'd34; end
            3'd6:    begin w_recip = 32'd2863311531; w_rsh = 6'd34; end
            3'd7:    begin w_recip = 32'd2454267027; w_rsh = 6'd34; end
            default: begin w_recip = 32'h8000_0000;  w_rsh = 6'd31; end
        endcase
    end

    // sequencer: product, range reduction, seven series terms, each divided by n
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= E_IDLE;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_st)
                E_IDLE: if (i_start) begin
                    r_y  <= 64'($signed(i_x) * $signed({1'b0, sae_pkg::Log2eQ30}));
                    r_st <= E_K;
                end
                E_K: begin
                    r_k  <= 64'($signed(r_y) >>> S);
                    r_st <= E_Z;
                end
                E_Z: begin
                    r_p  <= 64'(w_frac[31:0] * sae_pkg::Ln2Q30);
                    r_st <= E_ZR;
                end
                E_ZR: begin
                    r_z    <= 32'(r_p >> 30);
                    r_term <= 64'd1 << 30;
                    r_sum  <= 64'd1 << 30;
                    r_n    <= 3'd1;
                    r_st   <= E_T;
                end
                E_T: begin
                    r_term <= 64'(r_term[33:0] * r_z) >> 30;
                    r_st   <= E_DIV;
                end
                E_DIV: begin
                    r_quo <= 64'(r_term[31:0] * w_recip) >> w_rsh;
                    r_st  <= E_FIN;
                end
                E_FIN: begin
                    r_term <= r_quo;
                    r_sum  <= r_sum + r_quo;
                    if (r_n == 3'd7) begin
                        r_st <= E_IDLE;
                        r_done <= 1'b1;
                    end else begin
                        r_n  <= r_n + 3'd1;
                        r_st <= E_T;
                    end
                end
                default: r_st <= E_IDLE;
            endcase
        end
    end

    // shift and saturate after last term
    always_ff @(posedge i_clk) begin
        if (r_st == E_FIN && r_n == 3'd7) r_res <= 32'h0;
        if (r_done) r_res <= w_out;
    end

    assign o_done = r_done;
    assign o_y = w_out;
    logic w_unused;
    assign w_unused = ^r_res;
endmodule
`default_nettype wire

// File: sv/sae_datapath.sv
// Datapath: node stores, arithmetic and the value and gradient outputs for responses.
// Depends on sae_pkg, sae_ram, sae_exp.
`default_nettype none
module sae_datapath (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  sae_pkg::t_cmd        i_cmd,
    input  sae_pkg::t_req        i_req,
    input  wire  [7:0]           i_aux,   // second address
    output sae_pkg::t_stat       o_stat,
    output logic [31:0]          o_value,
    output logic [31:0]          o_grad
);
    localparam int AW = sae_pkg::IdxW;

    logic        w_vwe, w_gwe, w_mwe;
    logic [AW-1:0] w_vwa, w_gwa, w_ra0, w_ra1;
    logic [31:0] w_vwd, w_gwd;
    logic [31:0] w_v0, w_v1, w_g0, w_g1;
    logic [17:0] w_m0, w_m1;
    logic [17:0] w_mwd;

    logic [31:0] r_res;
    logic [63:0] r_pa, r_pb;
    logic [31:0] r_gv;
    logic [1:0]  r_kind;
    logic [7:0]  r_ca, r_cb;
    logic [7:0]  r_v;
    logic        r_exp_wait;
    logic [31:0] r_ga;
    logic        w_edone;
    logic [31:0] w_ey;

    sae_exp u_exp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_start(i_cmd.cmd == sae_pkg::C_ALU && i_cmd.op == sae_pkg::OP_EXP),
        .i_x(w_v0), .o_done(w_edone), .o_y(w_ey)
    );

    // read address mux; children come from the meta word or from r_ca/r_cb
    always_comb begin
        w_ra0 = i_cmd.addr;
        w_ra1 = i_aux;
        if (i_cmd.cmd == sae_pkg::C_RDC) begin
            w_ra0 = w_m0[15:8];
            w_ra1 = w_m0[7:0];
        end
        if (i_cmd.cmd == sae_pkg::C_PROD) w_ra0 = r_ca;
        if (i_cmd.cmd == sae_pkg::C_RDGB) w_ra0 = r_cb;
    end

    // write control
    always_comb begin
        w_vwe = i_cmd.cmd == sae_pkg::C_WNODE;
        w_mwe = w_vwe;
        w_vwa = i_cmd.addr;
        w_vwd = (i_req.opcode == sae_pkg::OP_LEAF) ? i_req.leaf_value : r_res;
        w_mwd = {i_req.opcode[1:0] - 2'd1,
                 (i_req.opcode == sae_pkg::OP_LEAF) ? 8'd0 : i_req.operand_a,
                 (i_req.opcode == sae_pkg::OP_LEAF || i_req.opcode == sae_pkg::OP_EXP)
                     ? 8'd0 : i_req.operand_b};
        w_gwe = 1'b1;
        w_gwa = i_cmd.addr;
        w_gwd = 32'd0;
        unique case (i_cmd.cmd)
            sae_pkg::C_WNODE, sae_pkg::C_GZERO: w_gwd = 32'd0;
            sae_pkg::C_GROOT: w_gwd = 32'd1 << sae_pkg::FractionBits;
            sae_pkg::C_WGA: begin
                w_gwa = r_ca;
                w_gwd = (r_kind == sae_pkg::K_ADD) ? sae_pkg::sat_add(w_g0, r_gv)
                        : sae_pkg::sat_add(w_g0, sae_pkg::sat_round(r_pa));
            end
            sae_pkg::C_WGB: begin
                w_gwa = r_cb;
                w_gwd = (r_kind == sae_pkg::K_ADD) ? sae_pkg::sat_add(w_g0, r_gv)
                        : sae_pkg::sat_add(w_g0, sae_pkg::sat_round(r_pb));
            end
            default: w_gwe = 1'b0;
        endcase
    end

    sae_ram #(.WIDTH(32), .DEPTH(sae_pkg::NodeCapacity)) u_val (
        .i_clk(i_clk), .i_we(w_vwe), .i_waddr(w_vwa), .i_wdata(w_vwd),
        .i_raddr0(w_ra0), .i_raddr1(w_ra1), .o_rdata0(w_v0), .o_rdata1(w_v1));
    sae_ram #(.WIDTH(32), .DEPTH(sae_pkg::NodeCapacity)) u_grad (
        .i_clk(i_clk), .i_we(w_gwe), .i_waddr(w_gwa), .i_wdata(w_gwd),
        .i_raddr0(w_ra0), .i_raddr1(w_ra1), .o_rdata0(w_g0), .o_rdata1(w_g1));
    sae_ram #(.WIDTH(18), .DEPTH(sae_pkg::NodeCapacity)) u_meta (
        .i_clk(i_clk), .i_we(w_mwe), .i_waddr(w_vwa), .i_wdata(w_mwd),
        .i_raddr0(w_ra0), .i_raddr1(w_ra1), .o_rdata0(w_m0), .o_rdata1(w_m1));

    // arithmetic registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_wait <= 1'b0;
        end else begin
            if (i_cmd.cmd == sae_pkg::C_ALU && i_cmd.op == sae_pkg::OP_EXP) r_exp_wait <= 1'b1;
            else if (w_edone) r_exp_wait <= 1'b0;
        end
        if (i_cmd.cmd == sae_pkg::C_ALU) begin
            if (i_cmd.op == sae_pkg::OP_ADD) r_res <= sae_pkg::sat_add(w_v0, w_v1);
            if (i_cmd.op == sae_pkg::OP_MUL) r_pa <= 64'($signed(w_v0) * $signed(w_v1));
        end
        if (r_exp_wait && w_edone) r_res <= w_ey;
        if (i_cmd.cmd == sae_pkg::C_RDRES && i_cmd.op == sae_pkg::OP_MUL)
            r_res <= sae_pkg::sat_round(r_pa);
        if (i_cmd.cmd == sae_pkg::C_RDV) r_v <= i_cmd.addr;
        if (i_cmd.cmd == sae_pkg::C_RDC) begin
            r_gv   <= w_g0;
            r_kind <= w_m0[17:16];
            r_ca   <= w_m0[15:8];
            r_cb   <= w_m0[7:0];
            r_ga   <= w_v0;  // own value
        end
        if (i_cmd.cmd == sae_pkg::C_PROD) begin
            if (r_kind == sae_pkg::K_MUL) begin
                r_pa <= 64'($signed(w_v1) * $signed(r_gv));
                r_pb <= 64'($signed(w_v0) * $signed(r_gv));
            end else begin
                r_pa <= 64'($signed(r_ga) * $signed(r_gv));
            end
        end
    end

    assign o_stat.busy = r_exp_wait;
    assign o_stat.kind = r_kind;
    // new node value while writing, else the registered read
    assign o_value = (i_cmd.cmd == sae_pkg::C_WNODE) ? r_res : w_v0;
    assign o_grad = w_g0;
    logic w_unused;
    assign w_unused = ^{w_m1, w_g1, r_v};
endmodule
`default_nettype wire

// File: sv/sae_ctrl.sv
// Controller: decodes requests, sequences the datapath, builds responses.
// Depends on sae_pkg.
`default_nettype none
module sae_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  sae_pkg::t_req        i_in,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output sae_pkg::t_rsp        o_out,
    output sae_pkg::t_cmd        o_cmd,
    output sae_pkg::t_req        o_req,
    output logic [7:0]           o_aux,
    input  sae_pkg::t_stat       i_stat,
    input  wire  [31:0]          i_value,
    input  wire  [31:0]          i_grad
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RDAB  = 4'd1;
    localparam logic [3:0] S_ALU   = 4'd2;
    localparam logic [3:0] S_WAIT  = 4'd3;
    localparam logic [3:0] S_WR    = 4'd4;
    localparam logic [3:0] S_ZERO  = 4'd5;
    localparam logic [3:0] S_VRD   = 4'd6;
    localparam logic [3:0] S_CRD   = 4'd7;
    localparam logic [3:0] S_PROD  = 4'd8;
    localparam logic [3:0] S_WGA   = 4'd9;
    localparam logic [3:0] S_RGB   = 4'd10;
    localparam logic [3:0] S_WGB   = 4'd11;
    localparam logic [3:0] S_RES   = 4'd12;
    localparam logic [3:0] S_RES2  = 4'd13;
    localparam logic [3:0] S_OUT   = 4'd14;
    localparam logic [3:0] S_MULR  = 4'd15;

    logic [3:0]  r_st;
    sae_pkg::t_req r_req;
    logic [8:0]  r_used;
    logic [8:0]  r_cnt;
    logic        r_last;
    sae_pkg::t_rsp r_rsp;
    logic        r_ov;
    logic [1:0]  r_ph;

    logic w_acc, w_bad, w_full;
    logic [8:0] w_a, w_b;

    assign w_acc = i_in_valid && o_in_ready;
    assign w_a = {1'b0, i_in.operand_a};
    assign w_b = {1'b0, i_in.operand_b};
    assign o_in_ready = (r_st == S_IDLE) && !r_ov;
    assign w_full = r_used >= 9'(sae_pkg::NodeCapacity);

    always_comb begin
        unique case (i_in.opcode)
            sae_pkg::OP_ADD, sae_pkg::OP_MUL: w_bad = w_a >= r_used || w_b >= r_used;
            sae_pkg::OP_EXP, sae_pkg::OP_BWD, sae_pkg::OP_READ: w_bad = w_a >= r_used;
            default: w_bad = 1'b0;
        endcase
    end

    // command decode
    always_comb begin
        o_cmd.cmd = sae_pkg::C_NONE;
        o_cmd.op = r_req.opcode;
        o_cmd.addr = r_req.operand_a;
        o_aux = r_req.operand_b;
        unique case (r_st)
            S_RDAB: o_cmd.cmd = sae_pkg::C_RDAB;
            S_ALU:  o_cmd.cmd = sae_pkg::C_ALU;
            S_MULR: o_cmd.cmd = sae_pkg::C_RDRES;
            S_WR:   begin o_cmd.cmd = sae_pkg::C_WNODE; o_cmd.addr = r_used[7:0]; end
            S_ZERO: begin
                o_cmd.cmd = r_last ? sae_pkg::C_GROOT : sae_pkg::C_GZERO;
                o_cmd.addr = r_last ? r_req.operand_a : r_cnt[7:0];
            end
            S_VRD:  begin o_cmd.cmd = sae_pkg::C_RDV; o_cmd.addr = r_cnt[7:0]; end
            S_CRD:  o_cmd.cmd = sae_pkg::C_RDC;
            S_PROD: o_cmd.cmd = sae_pkg::C_PROD;
            S_WGA:  o_cmd.cmd = (i_stat.kind == sae_pkg::K_LEAF) ? sae_pkg::C_NONE
                                : sae_pkg::C_WGA;
            S_RGB:  o_cmd.cmd = sae_pkg::C_RDGB;
            S_WGB:  o_cmd.cmd = sae_pkg::C_WGB;
            S_RES:  o_cmd.cmd = sae_pkg::C_RDAB;
            default: o_cmd.cmd = sae_pkg::C_NONE;
        endcase
    end

    assign o_req = r_req;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= S_IDLE;
            r_used <= 9'd0;
            r_ov   <= 1'b0;
        end else begin
            if (r_ov && i_out_ready) r_ov <= 1'b0;
            unique case (r_st)
                S_IDLE: if (w_acc) begin
                    r_req <= i_in;
                    r_rsp <= '0;
                    if (w_bad) begin
                        r_rsp.status <= sae_pkg::ST_BAD;
                        r_rsp.node_index <= i_in.operand_a;
                        r_ov <= 1'b1;
                    end else begin
                        unique case (i_in.opcode)
                            sae_pkg::OP_CLEAR: begin r_used <= 9'd0; r_ov <= 1'b1; end
                            sae_pkg::OP_LEAF, sae_pkg::OP_ADD, sae_pkg::OP_MUL,
                            sae_pkg::OP_EXP: begin
                                if (w_full) begin
                                    r_rsp.status <= sae_pkg::ST_FULL;
                                    r_ov <= 1'b1;
                                end else begin
                                    r_st <= (i_in.opcode == sae_pkg::OP_LEAF) ? S_WR : S_RDAB;
                                end
                            end
                            sae_pkg::OP_BWD: begin
                                r_cnt <= 9'd0; r_last <= 1'b0;
                                r_st <= S_ZERO;
                            end
                            sae_pkg::OP_READ: r_st <= S_RES;
                            default: r_ov <= 1'b1;
                        endcase
                    end
                end
                S_RDAB: r_st <= S_ALU;
                S_ALU: r_st <= (r_req.opcode == sae_pkg::OP_EXP) ? S_WAIT
                              : (r_req.opcode == sae_pkg::OP_MUL) ? S_MULR : S_WR;
                S_MULR: r_st <= S_WR;
                S_WAIT: if (!i_stat.busy) r_st <= S_WR;
                S_WR: begin
                    r_rsp.node_index <= r_used[7:0];
                    r_rsp.node_value <= (r_req.opcode == sae_pkg::OP_LEAF)
                                        ? r_req.leaf_value : i_value;
                    r_used <= r_used + 9'd1;
                    r_ov <= 1'b1;
                    r_st <= S_IDLE;
                end
                S_ZERO: begin
                    if (r_last) begin
                        r_cnt <= {1'b0, r_req.operand_a};
                        r_st <= S_VRD;
                    end else if (r_cnt + 9'd1 >= r_used) begin
                        r_last <= 1'b1;
                    end else begin
                        r_cnt <= r_cnt + 9'd1;
                    end
                end
                S_VRD: begin r_ph <= 2'd0; r_st <= S_CRD; end
                S_CRD: r_st <= S_PROD;
                S_PROD: r_st <= S_WGA;
                S_WGA: r_st <= (i_stat.kind == sae_pkg::K_LEAF
                               || i_stat.kind == sae_pkg::K_EXP) ? S_RES2 : S_RGB;
                S_RGB: r_st <= S_WGB;
                S_WGB: r_st <= S_RES2;
                S_RES2: begin
                    if (r_cnt == 9'd0) r_st <= S_RES;
                    else begin r_cnt <= r_cnt - 9'd1; r_st <= S_VRD; end
                end
                S_RES: r_st <= S_OUT;
                S_OUT: begin
                    r_rsp.node_index <= r_req.operand_a;
                    r_rsp.node_value <= i_value;
                    r_rsp.node_gradient <= i_grad;
                    r_ov <= 1'b1;
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_ov;
    assign o_out = r_rsp;
    logic w_unused;
    assign w_unused = ^r_ph;
endmodule
`default_nettype wire

// File: sv/scalar_autograd_engine.sv
// Top level of the scalar autograd engine: controller plus datapath.
// Depends on sae_pkg, sae_if, sae_ctrl, sae_datapath.
// One request at a time. Exp sums its series terms in the exp unit, with the
// divide by n done as a reciprocal multiply there.
// Backward first clears the gradients of the used nodes and sets the root's,
// then works through each node from the root down, bound by the single write
// port of the gradient memory. The result waits in an output register until taken.
`default_nettype none
module scalar_autograd_engine (
    input  wire       i_clk,
    input  wire       i_rst_n,
    sae_req_if.sink   i_req,
    sae_rsp_if.source o_rsp
);
    sae_pkg::t_cmd  w_cmd;
    sae_pkg::t_req  w_req;
    sae_pkg::t_stat w_stat;
    logic [7:0]     w_aux;
    logic [31:0]    w_value, w_grad;

    sae_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_req.valid), .o_in_ready(i_req.ready), .i_in(i_req.data),
        .o_out_valid(o_rsp.valid), .i_out_ready(o_rsp.ready), .o_out(o_rsp.data),
        .o_cmd(w_cmd), .o_req(w_req), .o_aux(w_aux), .i_stat(w_stat),
        .i_value(w_value), .i_grad(w_grad)
    );

    sae_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .i_req(w_req),
        .i_aux(w_aux), .o_stat(w_stat), .o_value(w_value), .o_grad(w_grad)
    );

    // no new request while a response waits
    a_no_accept_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> !i_req.ready) else $error("accept while response pending");
    // a response stays until taken
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && !o_rsp.ready |=> o_rsp.valid) else $error("response dropped");
    // no response is valid in the cycle a request is accepted
    a_accept_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready |-> !o_rsp.valid) else $error("overlap");
endmodule
`default_nettype wire

// File: tb/tb_scalar_autograd_engine.sv
// Testbench for scalar_autograd_engine: directed and random opcode streams,
// checked against an in-bench node-store predictor with random idling.
// Depends on sae_pkg, sae_if and the engine RTL.
module tb_scalar_autograd_engine;
    import sae_pkg::*;

    typedef logic signed [31:0] q_t;

    localparam int MaxQuiet  = 30000;  // cycles with no request or response
    localparam int DrainWait = 20;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    sae_req_if req_ch ();
    sae_rsp_if rsp_ch ();

    scalar_autograd_engine DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // predicted node store
    q_t         node_val  [NodeCapacity];
    q_t         node_grad [NodeCapacity];
    logic [1:0] node_kind [NodeCapacity];
    logic [7:0] node_left [NodeCapacity];
    logic [7:0] node_right[NodeCapacity];
    int         nodes_used = 0;

    t_rsp expected_rsp[$];
    int   err_cnt = 0;
    int   tx_idle = 0;
    int   rx_idle = 0;
    int   quiet_cycles = 0;

    function automatic q_t sat32(input longint v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return q_t'(v);
    endfunction

    function automatic q_t q_mul(input q_t a, input q_t b);
        longint p;
        p = longint'(a) * longint'(b) + (64'sd1 <<< (FractionBits - 1));
        return sat32(p >>> FractionBits);
    endfunction

    function automatic q_t q_exp(input q_t x);
        longint     y, k, sh, rs;
        bit [63:0]  frac, z, term, sum, v;
        y    = longint'(x) * longint'(Log2eQ30);
        k    = y >>> (FractionBits + 30);
        frac = 64'(y - (k <<< (FractionBits + 30))) >> FractionBits;
        z    = (frac * 64'(Ln2Q30)) >> 30;
        term = 64'd1 << 30;
        sum  = term;
        for (int n = 1; n <= 7; n++) begin
            term = ((term * z) >> 30) / 64'(n);
            sum += term;
        end
        sh = k + FractionBits - 30;
        if (sh >= 0) begin
            if (sh > 32) return 32'sh7FFF_FFFF;
            v = sum << sh;
            if (v > 64'h7FFF_FFFF) return 32'sh7FFF_FFFF;
            return q_t'(v[31:0]);
        end
        rs = -sh;
        if (rs >= 63) return '0;
        v = (sum + (64'd1 << (rs - 1))) >> rs;
        return q_t'(v[31:0]);
    endfunction

    // chain rule sweep from the root down to node 0
    function automatic void run_backward(input int root);
        q_t g;
        int a, b;
        for (int i = 0; i < nodes_used; i++) node_grad[i] = '0;
        node_grad[root] = q_t'(1) <<< FractionBits;
        for (int v = root; v >= 0; v--) begin
            g = node_grad[v];
            a = node_left[v];
            b = node_right[v];
            case (node_kind[v])
                K_ADD: begin
                    node_grad[a] = sat32(longint'(node_grad[a]) + g);
                    node_grad[b] = sat32(longint'(node_grad[b]) + g);
                end
                K_MUL: begin
                    node_grad[a] = sat32(longint'(node_grad[a]) + q_mul(node_val[b], g));
                    node_grad[b] = sat32(longint'(node_grad[b]) + q_mul(node_val[a], g));
                end
                K_EXP: begin
                    node_grad[a] = sat32(longint'(node_grad[a]) + q_mul(node_val[v], g));
                end
                default: ;
            endcase
        end
    endfunction

    // expected response for one request; updates the predicted store
    function automatic t_rsp engine_response(input t_req r);
        t_rsp o;
        int   a, b, idx;
        q_t   val;
        o = '0;
        a = r.operand_a;
        b = r.operand_b;
        case (r.opcode)
            OP_CLEAR: nodes_used = 0;
            OP_LEAF, OP_ADD, OP_MUL, OP_EXP: begin
                if (r.opcode != OP_LEAF &&
                    (a >= nodes_used || (r.opcode != OP_EXP && b >= nodes_used))) begin
                    o.status = ST_BAD;
                    o.node_index = r.operand_a;
                end else if (nodes_used >= NodeCapacity) begin
                    o.status = ST_FULL;
                end else begin
                    idx = nodes_used;
                    case (r.opcode)
                        OP_LEAF: begin val = q_t'(r.leaf_value); a = 0; b = 0; end
                        OP_ADD:  val = sat32(longint'(node_val[a]) + node_val[b]);
                        OP_MUL:  val = q_mul(node_val[a], node_val[b]);
                        default: begin val = q_exp(node_val[a]); b = 0; end
                    endcase
                    node_val[idx]   = val;
                    node_grad[idx]  = '0;
                    node_kind[idx]  = 2'(r.opcode - OP_LEAF);
                    node_left[idx]  = 8'(a);
                    node_right[idx] = 8'(b);
                    nodes_used      = idx + 1;
                    o.node_index    = 8'(idx);
                    o.node_value    = val;
                end
            end
            OP_BWD, OP_READ: begin
                o.node_index = r.operand_a;
                if (a >= nodes_used) begin
                    o.status = ST_BAD;
                end else begin
                    if (r.opcode == OP_BWD) run_backward(a);
                    o.node_value    = node_val[a];
                    o.node_gradient = node_grad[a];
                end
            end
            default: ;
        endcase
        return o;
    endfunction

    // send one request, idling at random first
    task automatic send_req(input t_req r);
        while ($urandom_range(0, 99) < tx_idle) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= r;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        expected_rsp.push_back(engine_response(r));
    endtask

    task automatic send_op(input logic [2:0] op, input logic [31:0] leaf,
                           input logic [7:0] a, input logic [7:0] b);
        t_req r;
        r.opcode = op;
        r.leaf_value = leaf;
        r.operand_a = a;
        r.operand_b = b;
        send_req(r);
    endtask

    // hold off until every outstanding response has come back
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_rsp.size() != 0) @(posedge i_clk);
    endtask

    // receiver stalls
    always @(posedge i_clk) begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= rx_idle);
    end

    // response checker
    always @(posedge i_clk) begin
        t_rsp want;
        if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_rsp.size() == 0) begin
                $error("response with no request outstanding");
                err_cnt++;
            end else begin
                want = expected_rsp.pop_front();
                if (rsp_ch.data.status !== want.status) begin
                    $error("status: expected %0d actual %0d", want.status, rsp_ch.data.status);
                    err_cnt++;
                end
                if (rsp_ch.data.node_index !== want.node_index) begin
                    $error("node_index: expected %0d actual %0d",
                           want.node_index, rsp_ch.data.node_index);
                    err_cnt++;
                end
                if (rsp_ch.data.node_value !== want.node_value) begin
                    $error("node_value: expected %h actual %h",
                           want.node_value, rsp_ch.data.node_value);
                    err_cnt++;
                end
                if (rsp_ch.data.node_gradient !== want.node_gradient) begin
                    $error("node_gradient: expected %h actual %h",
                           want.node_gradient, rsp_ch.data.node_gradient);
                    err_cnt++;
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= MaxQuiet) begin
            $display("tb_scalar_autograd_engine: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // a read, backward, a create and an unknown opcode on an empty store
    task automatic test_empty_store();
        send_op(OP_READ, '0, 8'd0, 8'd0);
        send_op(OP_BWD, '0, 8'd255, 8'd0);
        send_op(OP_ADD, '0, 8'd0, 8'd0);
        send_op(3'd7, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
    endtask

    // leaf extremes, saturating add and mul, exp range edges
    task automatic test_arith_edges();
        send_op(OP_LEAF, 32'h7FFF_FFFF, 8'hFF, 8'hFF);  // node 0
        send_op(OP_LEAF, 32'h8000_0000, 8'h00, 8'h00);  // node 1
        send_op(OP_LEAF, 32'h0001_8000, 8'h00, 8'h00);  // node 2: 1.5
        send_op(OP_ADD, '0, 8'd0, 8'd0);                // positive saturation
        send_op(OP_ADD, '0, 8'd1, 8'd1);                // negative saturation
        send_op(OP_MUL, '0, 8'd0, 8'd1);
        send_op(OP_MUL, '0, 8'd2, 8'd2);
        send_op(OP_EXP, '0, 8'd0, 8'hFF);               // saturates high
        send_op(OP_EXP, '0, 8'd1, 8'd0);                // underflows to zero
        send_op(OP_EXP, '0, 8'd2, 8'd0);
        send_op(OP_LEAF, '0, 8'd0, 8'd0);               // node 10: zero
        send_op(OP_EXP, '0, 8'd10, 8'd0);
    endtask

    // chain rule through add, mul and exp, then reads of the gradients
    task automatic test_backward_chain();
        send_op(OP_ADD, '0, 8'd2, 8'd11);               // node 12
        send_op(OP_MUL, '0, 8'd12, 8'd2);               // node 13
        send_op(OP_EXP, '0, 8'd13, 8'd0);               // node 14
        send_op(OP_BWD, '0, 8'd14, 8'd0);
        send_op(OP_READ, '0, 8'd2, 8'd0);
        send_op(OP_BWD, '0, 8'd5, 8'd0);                // mul of the extremes
        send_op(OP_READ, '0, 8'd0, 8'd0);
    endtask

    // bad operands on every operand field
    task automatic test_bad_operands();
        send_op(OP_ADD, '0, 8'd0, 8'd200);
        send_op(OP_MUL, '0, 8'd255, 8'd0);
        send_op(OP_EXP, '0, 8'd15, 8'd0);
        send_op(OP_READ, '0, 8'd128, 8'd0);
    endtask

    // fill the store, then full, backward and read checks on the last node, and a bad operand after clear
    task automatic test_store_full();
        send_op(OP_CLEAR, '0, 8'd0, 8'd0);
        for (int i = 0; i < NodeCapacity; i++)
            send_op(OP_LEAF, $urandom, 8'($urandom), 8'($urandom));
        send_op(OP_LEAF, 32'h1234_5678, 8'd0, 8'd0);
        send_op(OP_ADD, '0, 8'd3, 8'd255);
        send_op(OP_BWD, '0, 8'd255, 8'd0);
        send_op(OP_READ, '0, 8'd255, 8'd0);
        send_op(OP_CLEAR, '0, 8'd0, 8'd0);
        send_op(OP_MUL, '0, 8'd0, 8'd0);                // bad after clear
    endtask

    function automatic logic [31:0] random_leaf();
        if ($urandom_range(0, 9) < 7) return 32'($urandom_range(0, 32'h3FFFF)) - 32'h20000;
        return $urandom;
    endfunction

    // mostly well-formed graph building with occasional noise
    task automatic test_random(input int count);
        int         sel;
        logic [2:0] op;
        logic [7:0] a, b;
        for (int i = 0; i < count; i++) begin
            sel = $urandom_range(0, 99);
            a = 8'($urandom);
            b = 8'($urandom);
            if (nodes_used == 0 && sel >= 3 && sel < 95) sel = 10;
            if (sel < 3)       op = OP_CLEAR;
            else if (sel < 30) op = OP_LEAF;
            else if (sel < 50) op = OP_ADD;
            else if (sel < 68) op = OP_MUL;
            else if (sel < 74) op = OP_EXP;
            else if (sel < 82) op = OP_BWD;
            else if (sel < 95) op = OP_READ;
            else if (sel < 97) op = 3'd7;
            else               op = 3'($urandom_range(2, 6));
            if (sel >= 30 && sel < 95) begin
                a = 8'($urandom_range(0, nodes_used - 1));
                b = 8'($urandom_range(0, nodes_used - 1));
            end
            send_op(op, random_leaf(), a, b);
            if (i % 150 == 149) wait_drained();
        end
    endtask

    initial begin
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        rsp_ch.ready = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        tx_idle = 16;
        rx_idle = 81;
        test_empty_store();
        test_arith_edges();
        test_backward_chain();
        test_bad_operands();
        wait_drained();
        test_store_full();
        test_random(350);

        tx_idle = 81;
        rx_idle = 16;
        test_random(350);

        tx_idle = 0;
        rx_idle = 0;
        test_random(350);

        wait_drained();
        repeat (DrainWait) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("tb_scalar_autograd_engine: clean");
        end else begin
            $display("tb_scalar_autograd_engine: errors");
        end
        $finish;
    end
endmodule
